[sv/http2_frame_deframer_top_assert.svh]
// Assertion macros used by the deframer checker.
`ifndef HTTP2_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define HTTP2_FRAME_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define H2FD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("h2fd check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define H2FD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("h2fd check failed");

`endif

[sv/h2fd_pkg.sv]
// ----------------------------------------------------------------------------
// h2fd_pkg
// Event kinds, fault codes, frame types and the event record of the deframer.
// ----------------------------------------------------------------------------
package h2fd_pkg;

    // event kinds
    localparam logic [3:0] EV_HEADER  = 4'd0;
    localparam logic [3:0] EV_CONTENT = 4'd1;
    localparam logic [3:0] EV_PRIO    = 4'd2;
    localparam logic [3:0] EV_RST     = 4'd3;
    localparam logic [3:0] EV_SETTING = 4'd4;
    localparam logic [3:0] EV_PING    = 4'd5;
    localparam logic [3:0] EV_GOAWAY  = 4'd6;
    localparam logic [3:0] EV_WINDOW  = 4'd7;
    localparam logic [3:0] EV_END     = 4'd8;
    localparam logic [3:0] EV_ERROR   = 4'd9;

    // fault codes
    localparam logic [2:0] FC_NONE       = 3'd0;
    localparam logic [2:0] FC_BAD_TYPE   = 3'd1;
    localparam logic [2:0] FC_NO_PAD     = 3'd2;
    localparam logic [2:0] FC_PAD_LONG   = 3'd3;
    localparam logic [2:0] FC_SHORT_PRIO = 3'd4;
    localparam logic [2:0] FC_BAD_SIZE   = 3'd5;
    localparam logic [2:0] FC_SET_MOD6   = 3'd6;

    // frame types
    localparam logic [7:0] FT_DATA     = 8'd0;
    localparam logic [7:0] FT_HEADERS  = 8'd1;
    localparam logic [7:0] FT_PRIORITY = 8'd2;
    localparam logic [7:0] FT_RST      = 8'd3;
    localparam logic [7:0] FT_SETTINGS = 8'd4;
    localparam logic [7:0] FT_PUSH     = 8'd5;
    localparam logic [7:0] FT_PING     = 8'd6;
    localparam logic [7:0] FT_GOAWAY   = 8'd7;
    localparam logic [7:0] FT_WINDOW   = 8'd8;
    localparam logic [7:0] FT_LAST     = 8'd9;

    // flag bit positions
    localparam int FLB_PADDED   = 3;
    localparam int FLB_PRIORITY = 5;

    typedef struct packed {
        logic [3:0]  kind;
        logic [23:0] length;
        logic [7:0]  ftype;
        logic [7:0]  flags;
        logic [30:0] stream;
        logic [31:0] value_first;
        logic [63:0] value_second;
        logic        excl;
        logic        last;
        logic [2:0]  fault;
    } t_event;

    // remainder by six of a byte: reciprocal multiply, then one subtract
    function automatic logic [2:0] mod6_8(input logic [7:0] v);
        logic [15:0] prod;
        logic [5:0]  q;
        logic [8:0]  r;
        prod = {8'd0, v} * 16'd171;
        q    = prod[15:10];
        r    = {1'b0, v} - ({3'd0, q} * 9'd6);
        return r[2:0];
    endfunction

endpackage

[sv/h2fd_core.sv]
// ----------------------------------------------------------------------------
// h2fd_core
// Frame parse state and the per-byte decode into one optional event.
// ----------------------------------------------------------------------------
module h2fd_core
    import h2fd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    output t_event     o_evt,
    output logic       o_evt_valid
);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_SKIP    = 2'd2;

    logic [1:0]  r_phase,  n_phase;
    logic [23:0] r_pos,    n_pos;
    logic [23:0] r_len,    n_len;
    logic [2:0]  r_len_m6, n_len_m6;
    logic [7:0]  r_type,   n_type;
    logic [7:0]  r_flags,  n_flags;
    logic [30:0] r_stream, n_stream;
    logic [7:0]  r_pad,    n_pad;
    logic [63:0] r_field,  n_field;
    logic [31:0] r_aux,    n_aux;
    logic [2:0]  r_set_m6, n_set_m6;

    logic [24:0] pos_inc;
    logic        last;
    logic [63:0] field_next;
    logic [31:0] aux_next;
    logic        padded;
    logic        prio;
    logic [8:0]  pad_need;
    logic [2:0]  hdr_fault;

    logic        ev_emit;
    logic [3:0]  ev_kind;
    logic [31:0] ev_v1;
    logic [63:0] ev_v2;
    logic        ev_excl;
    logic        ev_last;
    logic [2:0]  ev_fault;

    assign pos_inc    = {1'b0, r_pos} + 25'd1;
    assign last       = pos_inc >= {1'b0, r_len};
    assign field_next = {r_field[55:0], i_byte};
    assign aux_next   = {r_aux[23:0], i_byte};
    assign padded     = ((r_type == FT_DATA) || (r_type == FT_HEADERS)) && r_flags[FLB_PADDED];
    assign prio       = (r_type == FT_HEADERS) && r_flags[FLB_PRIORITY];
    assign pad_need   = {8'd0, padded} + (prio ? 9'd5 : 9'd0) + {1'b0, i_byte};

    // header checks, first match wins
    always_comb begin
        priority if ((r_type == FT_PUSH) || (r_type > FT_LAST)) begin
            hdr_fault = FC_BAD_TYPE;
        end else if (padded && (r_len == 24'd0)) begin
            hdr_fault = FC_NO_PAD;
        end else if (prio && (r_len < (padded ? 24'd6 : 24'd5))) begin
            hdr_fault = FC_SHORT_PRIO;
        end else if ((r_type == FT_PRIORITY) && (r_len != 24'd5)) begin
            hdr_fault = FC_BAD_SIZE;
        end else if (((r_type == FT_RST) || (r_type == FT_WINDOW)) && (r_len != 24'd4)) begin
            hdr_fault = FC_BAD_SIZE;
        end else if ((r_type == FT_PING) && (r_len != 24'd8)) begin
            hdr_fault = FC_BAD_SIZE;
        end else if ((r_type == FT_GOAWAY) && (r_len < 24'd8)) begin
            hdr_fault = FC_BAD_SIZE;
        end else if ((r_type == FT_SETTINGS) && (r_len_m6 != 3'd0)) begin
            hdr_fault = FC_SET_MOD6;
        end else begin
            hdr_fault = FC_NONE;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_len    = r_len;
        n_len_m6 = r_len_m6;
        n_type   = r_type;
        n_flags  = r_flags;
        n_stream = r_stream;
        n_pad    = r_pad;
        n_field  = r_field;
        n_aux    = r_aux;
        n_set_m6 = r_set_m6;

        ev_emit  = 1'b0;
        ev_kind  = EV_END;
        ev_v1    = 32'd0;
        ev_v2    = 64'd0;
        ev_excl  = 1'b0;
        ev_last  = last;
        ev_fault = FC_NONE;

        if ((r_phase != PH_PAYLOAD) && (r_phase != PH_SKIP)) begin
            n_phase = PH_HEADER;
            priority if (r_pos == 24'd0) begin
                n_len    = {16'd0, i_byte};
                n_len_m6 = mod6_8(i_byte);
            end else if (r_pos <= 24'd2) begin
                n_len    = {r_len[15:0], i_byte};
                // 256 mod 6 is 4
                n_len_m6 = mod6_8({3'd0, r_len_m6, 2'b00} + {5'd0, mod6_8(i_byte)});
            end else if (r_pos == 24'd3) begin
                n_type = i_byte;
            end else if (r_pos == 24'd4) begin
                n_flags = i_byte;
            end else if (r_pos == 24'd5) begin
                n_stream = {23'd0, i_byte};
            end else begin
                n_stream = {r_stream[22:0], i_byte};
            end

            if (r_pos < 24'd8) begin
                n_pos = r_pos + 24'd1;
            end else begin
                n_pos    = 24'd0;
                n_pad    = 8'd0;
                n_field  = 64'd0;
                n_aux    = 32'd0;
                n_set_m6 = 3'd0;
                ev_emit  = 1'b1;
                ev_last  = (r_len == 24'd0);
                if (hdr_fault != FC_NONE) begin
                    ev_kind  = EV_ERROR;
                    ev_fault = hdr_fault;
                    n_phase  = (r_len == 24'd0) ? PH_HEADER : PH_SKIP;
                end else begin
                    ev_kind = EV_HEADER;
                    n_phase = (r_len == 24'd0) ? PH_HEADER : PH_PAYLOAD;
                end
            end
        end else begin
            // silent bytes report only the frame end
            ev_emit = last;
            if (r_phase == PH_PAYLOAD) begin
                n_field = field_next;
                unique case (r_type)
                    FT_DATA, FT_HEADERS: begin
                        if (padded && (r_pos == 24'd0)) begin
                            n_pad = i_byte;
                            if ({15'd0, pad_need} > r_len) begin
                                n_phase  = PH_SKIP;
                                ev_emit  = 1'b1;
                                ev_kind  = EV_ERROR;
                                ev_fault = FC_PAD_LONG;
                            end
                        end else if (prio && (r_pos < (padded ? 24'd6 : 24'd5))) begin
                            if (r_pos < (padded ? 24'd5 : 24'd4)) begin
                                n_aux = aux_next;
                            end else begin
                                ev_emit = 1'b1;
                                ev_kind = EV_PRIO;
                                ev_v1   = {1'b0, r_aux[30:0]};
                                ev_v2   = {56'd0, i_byte};
                                ev_excl = r_aux[31];
                            end
                        end else if (r_pos < (r_len - {16'd0, r_pad})) begin
                            ev_emit = 1'b1;
                            ev_kind = EV_CONTENT;
                            ev_v1   = {24'd0, i_byte};
                        end
                    end
                    FT_PRIORITY: begin
                        if (r_pos < 24'd4) begin
                            n_aux = aux_next;
                        end else begin
                            ev_emit = 1'b1;
                            ev_kind = EV_PRIO;
                            ev_v1   = {1'b0, r_aux[30:0]};
                            ev_v2   = {56'd0, i_byte};
                            ev_excl = r_aux[31];
                        end
                    end
                    FT_RST, FT_WINDOW: begin
                        n_aux = aux_next;
                        if (r_pos >= 24'd3) begin
                            ev_emit = 1'b1;
                            if (r_type == FT_RST) begin
                                ev_kind = EV_RST;
                                ev_v1   = aux_next;
                            end else begin
                                ev_kind = EV_WINDOW;
                                ev_v1   = {1'b0, aux_next[30:0]};
                            end
                        end
                    end
                    FT_SETTINGS: begin
                        n_set_m6 = (r_set_m6 == 3'd5) ? 3'd0 : r_set_m6 + 3'd1;
                        if (r_set_m6 == 3'd5) begin
                            ev_emit = 1'b1;
                            ev_kind = EV_SETTING;
                            ev_v1   = {16'd0, field_next[47:32]};
                            ev_v2   = {32'd0, field_next[31:0]};
                        end
                    end
                    FT_PING: begin
                        if (r_pos >= 24'd7) begin
                            ev_emit = 1'b1;
                            ev_kind = EV_PING;
                            ev_v2   = field_next;
                        end
                    end
                    FT_GOAWAY: begin
                        priority if (r_pos < 24'd4) begin
                            n_aux = aux_next;
                        end else if (r_pos < 24'd7) begin
                            n_aux = r_aux;
                        end else if (r_pos == 24'd7) begin
                            ev_emit = 1'b1;
                            ev_kind = EV_GOAWAY;
                            ev_v1   = {1'b0, r_aux[30:0]};
                            ev_v2   = {32'd0, field_next[31:0]};
                        end else begin
                            ev_emit = 1'b1;
                            ev_kind = EV_CONTENT;
                            ev_v1   = {24'd0, i_byte};
                        end
                    end
                    default: begin
                        ev_emit = 1'b1;
                        ev_kind = EV_CONTENT;
                        ev_v1   = {24'd0, i_byte};
                    end
                endcase
            end

            if (last) begin
                n_phase = PH_HEADER;
                n_pos   = 24'd0;
            end else begin
                n_pos = pos_inc[23:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= 24'd0;
            r_len    <= 24'd0;
            r_len_m6 <= 3'd0;
            r_type   <= 8'd0;
            r_flags  <= 8'd0;
            r_stream <= 31'd0;
            r_pad    <= 8'd0;
            r_field  <= 64'd0;
            r_aux    <= 32'd0;
            r_set_m6 <= 3'd0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_len_m6 <= n_len_m6;
            r_type   <= n_type;
            r_flags  <= n_flags;
            r_stream <= n_stream;
            r_pad    <= n_pad;
            r_field  <= n_field;
            r_aux    <= n_aux;
            r_set_m6 <= n_set_m6;
        end
    end

    // every event carries the header as it stands after this byte
    always_comb begin
        o_evt.kind         = ev_kind;
        o_evt.length       = n_len;
        o_evt.ftype        = n_type;
        o_evt.flags        = n_flags;
        o_evt.stream       = n_stream;
        o_evt.value_first  = ev_v1;
        o_evt.value_second = ev_v2;
        o_evt.excl         = ev_excl;
        o_evt.last         = ev_last;
        o_evt.fault        = ev_fault;
    end

    assign o_evt_valid = ev_emit;

endmodule

[sv/http2_frame_deframer_top.sv]
// ----------------------------------------------------------------------------
// http2_frame_deframer_top
// HTTP/2 frame deframer: one stream byte in, at most one decoded event out.
// ----------------------------------------------------------------------------
//  Channel | Handshake                  | Payload
//  --------+----------------------------+-------------------------------------
//  in      | i_in_valid / o_in_stall    | i_stream_byte
//  out     | o_out_valid / i_out_stall  | o_event_kind .. o_fault_code
//
//  One byte per clock unless a stalled event holds it; each byte passes the
//  input register, then the decode, then the event register.
//  Synchronous active-low reset returns to header collection.
//  A stalled event holds the byte behind it; bytes that give no event keep
//  moving while the output waits.
// ----------------------------------------------------------------------------
module http2_frame_deframer_top
    import h2fd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_stream_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_event_kind,
    output logic [23:0] o_frame_length,
    output logic [7:0]  o_frame_type,
    output logic [7:0]  o_frame_flags,
    output logic [30:0] o_stream_ident,
    output logic [31:0] o_value_first,
    output logic [63:0] o_value_second,
    output logic        o_exclusive_bit,
    output logic        o_frame_end,
    output logic [2:0]  o_fault_code
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_event     r_out;

    t_event     evt;
    logic       evt_valid;
    logic       out_free;
    logic       advance;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!evt_valid || out_free);
    assign o_in_stall = r_in_valid && !advance;

    h2fd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (advance),
        .i_byte      (r_in_byte),
        .o_evt       (evt),
        .o_evt_valid (evt_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_stream_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && evt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && evt_valid) begin
            r_out <= evt;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_kind    = r_out.kind;
    assign o_frame_length  = r_out.length;
    assign o_frame_type    = r_out.ftype;
    assign o_frame_flags   = r_out.flags;
    assign o_stream_ident  = r_out.stream;
    assign o_value_first   = r_out.value_first;
    assign o_value_second  = r_out.value_second;
    assign o_exclusive_bit = r_out.excl;
    assign o_frame_end     = r_out.last;
    assign o_fault_code    = r_out.fault;

endmodule

[sv/h2fd_checker.sv]
// ----------------------------------------------------------------------------
// h2fd_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "http2_frame_deframer_top_assert.svh"

module h2fd_checker
    import h2fd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [7:0]  i_stream_byte,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [3:0]  o_event_kind,
    input logic [23:0] o_frame_length,
    input logic [7:0]  o_frame_type,
    input logic [7:0]  o_frame_flags,
    input logic [30:0] o_stream_ident,
    input logic [31:0] o_value_first,
    input logic [63:0] o_value_second,
    input logic        o_exclusive_bit,
    input logic        o_frame_end,
    input logic [2:0]  o_fault_code
);

    // a stalled event stays put
    `H2FD_ASSERT_NEXT(a_out_hold, i_rst_n && o_out_valid && i_out_stall, o_out_valid && $stable(o_event_kind) && $stable(o_value_second))

    // fault code present exactly on error events
    `H2FD_ASSERT_NOW(a_err_fault, o_out_valid && (o_event_kind == EV_ERROR), o_fault_code != FC_NONE)
    `H2FD_ASSERT_NOW(a_ok_nofault, o_out_valid && (o_event_kind != EV_ERROR), o_fault_code == FC_NONE)

    // an end event always closes a frame
    `H2FD_ASSERT_NOW(a_end_last, o_out_valid && (o_event_kind == EV_END), o_frame_end)

    // a header ends the frame only when the payload is empty
    `H2FD_ASSERT_NOW(a_hdr_end, o_out_valid && (o_event_kind == EV_HEADER), o_frame_end == (o_frame_length == 24'd0))

endmodule

bind http2_frame_deframer_top h2fd_checker u_h2fd_checker (.*);
